>>> sv/tcce_pkg.sv
// tcce_pkg: shared types and constants for the text console character engine
// payload structs, operation codes, control codes and controller/datapath link types
// no dependencies
`default_nettype none

package tcce_pkg;

  // default screen geometry
  localparam int COLUMNS_DEF = 80;
  localparam int ROWS_DEF    = 25;

  // output field widths
  localparam int COL_OUT_W = 7;
  localparam int ROW_OUT_W = 5;
  localparam int POS_OUT_W = 11;

  // operations
  localparam logic [1:0] OP_PUT   = 2'd0;
  localparam logic [1:0] OP_CLEAR = 2'd1;
  localparam logic [1:0] OP_SET   = 2'd2;
  localparam logic [1:0] OP_READ  = 2'd3;

  // control characters
  localparam logic [7:0] CH_BS  = 8'd8;
  localparam logic [7:0] CH_TAB = 8'd9;
  localparam logic [7:0] CH_LF  = 8'd10;
  localparam logic [7:0] CH_CR  = 8'd13;

  localparam logic [7:0] BLANK_CHAR = 8'h20;
  localparam logic [7:0] RESET_ATTR = 8'h07;
  localparam int         TAB_STEP   = 8;

  typedef struct packed {
    logic [1:0] operation;
    logic [7:0] char_code;
    logic [7:0] col_in;
    logic [7:0] row_in;
  } in_t;

  typedef struct packed {
    logic [COL_OUT_W-1:0] cursor_col;
    logic [ROW_OUT_W-1:0] cursor_row;
    logic [POS_OUT_W-1:0] cursor_position;
    logic [15:0]          cell_data;
    logic                 scrolled;
  } out_t;

  // controller to datapath
  typedef struct packed {
    logic load_in;     // capture the input transaction
    logic exec;        // apply the operation to cursor and single cell
    logic rd_cell;     // read the addressed cell
    logic ptr_zero;    // sweep pointer to zero
    logic ptr_inc;     // sweep pointer advance
    logic copy_rd;     // scroll copy read, write follows in the next cycle
    logic blank_wr;    // write a blank at the sweep pointer
    logic init_color;  // blank uses the reset attribute
    logic out_load;    // load the result register
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic [1:0] op;
    logic       scroll_need;
    logic       copy_last;
    logic       cell_last;
    logic       out_free;
  } stat_t;

endpackage

`default_nettype wire

>>> sv/tcce_ctrl.sv
// tcce_ctrl: sequencing state machine for the text console character engine
// drives datapath commands from handshake and datapath status; uses tcce_pkg
`default_nettype none

module tcce_ctrl import tcce_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  in_valid,
  output logic  in_ready,
  input  stat_t stat,
  output cmd_t  cmd
);

  typedef enum logic [2:0] {
    S_INIT,
    S_IDLE,
    S_EXEC,
    S_READ,
    S_SCROLL,
    S_DRAIN,
    S_FILL,
    S_RESP
  } state_t;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_INIT;
    end else begin
      state <= state_next;
    end
  end

  assign in_ready = (state == S_IDLE);

  always_comb begin
    cmd        = '0;
    state_next = state;
    unique case (state)
      S_INIT: begin
        cmd.blank_wr   = 1'b1;
        cmd.init_color = 1'b1;
        cmd.ptr_inc    = !stat.cell_last;
        if (stat.cell_last) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid) begin
          cmd.load_in = 1'b1;
          state_next  = S_EXEC;
        end
      end
      S_EXEC: begin
        cmd.exec = 1'b1;
        priority if (stat.op == OP_READ) begin
          cmd.rd_cell = 1'b1;
          state_next  = S_READ;
        end else if (stat.op == OP_CLEAR) begin
          cmd.ptr_zero = 1'b1;
          state_next   = S_FILL;
        end else if (stat.op == OP_PUT && stat.scroll_need) begin
          cmd.ptr_zero = 1'b1;
          state_next   = S_SCROLL;
        end else if (stat.out_free) begin
          cmd.out_load = 1'b1;
          state_next   = S_IDLE;
        end else begin
          state_next = S_RESP;
        end
      end
      S_READ, S_RESP: begin
        if (stat.out_free) begin
          cmd.out_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      S_SCROLL: begin
        cmd.copy_rd = 1'b1;
        cmd.ptr_inc = 1'b1;
        if (stat.copy_last) begin
          state_next = S_DRAIN;
        end
      end
      S_DRAIN: begin
        state_next = S_FILL;
      end
      S_FILL: begin
        cmd.blank_wr = 1'b1;
        cmd.ptr_inc  = !stat.cell_last;
        if (stat.cell_last) begin
          state_next = S_RESP;
        end
      end
      default: begin
        state_next = S_INIT;
      end
    endcase
  end

endmodule

`default_nettype wire

>>> sv/tcce_datapath.sv
// tcce_datapath: cursor, screen store, sweep pointer and result register
// of the text console character engine; uses tcce_pkg, driven by tcce_ctrl
`default_nettype none

module tcce_datapath import tcce_pkg::*; #(
  parameter int COLUMNS = COLUMNS_DEF,
  parameter int ROWS    = ROWS_DEF
) (
  input  logic       clk,
  input  logic       rst,
  input  in_t        in_data,
  input  logic       cfg_we,
  input  logic [7:0] cfg_wdata,
  input  cmd_t       cmd,
  output stat_t      stat,
  input  logic       out_ready,
  output logic       out_valid,
  output out_t       out_data
);

  localparam int CELLS   = COLUMNS * ROWS;
  localparam int ADDR_W  = $clog2(CELLS);
  localparam int COL_W   = $clog2(COLUMNS);
  localparam int ROW_W   = $clog2(ROWS);
  localparam int CALC_CW = $clog2(COLUMNS + TAB_STEP);
  localparam int CALC_RW = $clog2(ROWS + 1);
  localparam int OCW     = (COL_W > COL_OUT_W) ? COL_W : COL_OUT_W;
  localparam int ORW     = (ROW_W > ROW_OUT_W) ? ROW_W : ROW_OUT_W;
  localparam int OPW     = (ADDR_W > POS_OUT_W) ? ADDR_W : POS_OUT_W;

  localparam logic [7:0]        CLAMP_COL = 8'(COLUMNS - 1);
  localparam logic [7:0]        CLAMP_ROW = 8'(ROWS - 1);
  localparam logic [COL_W-1:0]  LAST_COL  = COL_W'(COLUMNS - 1);
  localparam logic [ROW_W-1:0]  LAST_ROW  = ROW_W'(ROWS - 1);
  localparam logic [ADDR_W-1:0] COLS_A    = ADDR_W'(COLUMNS);
  localparam logic [ADDR_W-1:0] COPY_LAST = ADDR_W'(CELLS - COLUMNS - 1);
  localparam logic [ADDR_W-1:0] CELL_LAST = ADDR_W'(CELLS - 1);
  localparam logic [CALC_CW-1:0] COLS_C   = CALC_CW'(COLUMNS);
  localparam logic [CALC_CW-1:0] TAB_C    = CALC_CW'(TAB_STEP);
  localparam logic [CALC_RW-1:0] ROWS_C   = CALC_RW'(ROWS);
  localparam logic [OPW-1:0]     COLS_P   = OPW'(COLUMNS);

  logic [7:0]        text_color;
  logic [1:0]        op_q;
  logic [7:0]        char_q;
  logic [COL_W-1:0]  col_q;
  logic [ROW_W-1:0]  row_q;
  logic [COL_W-1:0]  cur_col;
  logic [ROW_W-1:0]  cur_row;
  logic              scr;
  logic [ADDR_W-1:0] ptr;
  logic              pend;
  logic [ADDR_W-1:0] pend_addr;
  logic [15:0]       rdata;
  logic [15:0]       mem [CELLS];

  logic [CALC_CW-1:0] col_x, tab_col, inc_col, put_col;
  logic [CALC_RW-1:0] row_x, put_row;
  logic               put_wr;
  logic [COL_W-1:0]   put_wcol;
  logic [7:0]         put_char;
  logic               scroll_need;
  logic               exec_wr;
  logic [ADDR_W-1:0]  exec_addr, cell_addr;
  logic [COL_W-1:0]   cur_col_next;
  logic [ROW_W-1:0]   cur_row_next;
  logic               scr_next;
  logic               we, re;
  logic [ADDR_W-1:0]  waddr, raddr;
  logic [15:0]        wdata;
  logic [OCW-1:0]     col_o;
  logic [ORW-1:0]     row_o;
  logic [OPW-1:0]     pos_o;

  // configuration
  always_ff @(posedge clk) begin
    if (rst) begin
      text_color <= RESET_ATTR;
    end else if (cfg_we) begin
      text_color <= cfg_wdata;
    end
  end

  // input capture with coordinate clamp
  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      op_q   <= in_data.operation;
      char_q <= in_data.char_code;
      col_q  <= (in_data.col_in > CLAMP_COL) ? LAST_COL : COL_W'(in_data.col_in);
      row_q  <= (in_data.row_in > CLAMP_ROW) ? LAST_ROW : ROW_W'(in_data.row_in);
    end
  end

  // put character cursor logic
  always_comb begin
    col_x    = CALC_CW'(cur_col);
    row_x    = CALC_RW'(cur_row);
    tab_col  = (col_x + TAB_C) & ~CALC_CW'(TAB_STEP - 1);
    inc_col  = col_x + CALC_CW'(1);
    put_col  = col_x;
    put_row  = row_x;
    put_wr   = 1'b0;
    put_wcol = cur_col;
    put_char = char_q;
    priority if (char_q == CH_LF) begin
      put_col = '0;
      put_row = row_x + CALC_RW'(1);
    end else if (char_q == CH_CR) begin
      put_col = '0;
    end else if (char_q == CH_TAB) begin
      if (tab_col >= COLS_C) begin
        put_col = '0;
        put_row = row_x + CALC_RW'(1);
      end else begin
        put_col = tab_col;
      end
    end else if (char_q == CH_BS) begin
      if (cur_col != '0) begin
        put_col  = col_x - CALC_CW'(1);
        put_wr   = 1'b1;
        put_wcol = cur_col - COL_W'(1);
        put_char = BLANK_CHAR;
      end
    end else begin
      put_wr = 1'b1;
      if (inc_col >= COLS_C) begin
        put_col = '0;
        put_row = row_x + CALC_RW'(1);
      end else begin
        put_col = inc_col;
      end
    end
    scroll_need = (put_row >= ROWS_C);
  end

  assign exec_wr   = cmd.exec && (op_q == OP_PUT) && put_wr;
  assign exec_addr = ADDR_W'(cur_row) * COLS_A + ADDR_W'(put_wcol);
  assign cell_addr = ADDR_W'(row_q) * COLS_A + ADDR_W'(col_q);

  // cursor next values, also feed the result when loaded in the same cycle
  always_comb begin
    cur_col_next = cur_col;
    cur_row_next = cur_row;
    scr_next     = scr;
    if (cmd.exec) begin
      scr_next = 1'b0;
      unique case (op_q)
        OP_PUT: begin
          cur_col_next = COL_W'(put_col);
          cur_row_next = scroll_need ? LAST_ROW : ROW_W'(put_row);
          scr_next     = scroll_need;
        end
        OP_CLEAR: begin
          cur_col_next = '0;
          cur_row_next = '0;
        end
        OP_SET: begin
          cur_col_next = col_q;
          cur_row_next = row_q;
        end
        OP_READ: begin
          cur_col_next = cur_col;
          cur_row_next = cur_row;
        end
        default: begin
          cur_col_next = cur_col;
          cur_row_next = cur_row;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cur_col <= '0;
      cur_row <= '0;
      scr     <= 1'b0;
    end else begin
      cur_col <= cur_col_next;
      cur_row <= cur_row_next;
      scr     <= scr_next;
    end
  end

  // sweep pointer and copy pipeline
  always_ff @(posedge clk) begin
    if (rst) begin
      ptr  <= '0;
      pend <= 1'b0;
    end else begin
      pend <= cmd.copy_rd;
      if (cmd.ptr_zero) begin
        ptr <= '0;
      end else if (cmd.ptr_inc) begin
        ptr <= ptr + ADDR_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    pend_addr <= ptr;
  end

  // screen store ports
  always_comb begin
    we    = 1'b0;
    waddr = ptr;
    wdata = {text_color, BLANK_CHAR};
    priority if (pend) begin
      we    = 1'b1;
      waddr = pend_addr;
      wdata = rdata;
    end else if (cmd.blank_wr) begin
      we    = 1'b1;
      wdata = {cmd.init_color ? RESET_ATTR : text_color, BLANK_CHAR};
    end else if (exec_wr) begin
      we    = 1'b1;
      waddr = exec_addr;
      wdata = {text_color, put_char};
    end
  end

  assign re    = cmd.rd_cell || cmd.copy_rd;
  assign raddr = cmd.rd_cell ? cell_addr : ptr + COLS_A;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

  // result register
  assign col_o = OCW'(cur_col_next);
  assign row_o = ORW'(cur_row_next);
  assign pos_o = OPW'(cur_row_next) * COLS_P + OPW'(cur_col_next);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_data.cursor_col      <= col_o[COL_OUT_W-1:0];
      out_data.cursor_row      <= row_o[ROW_OUT_W-1:0];
      out_data.cursor_position <= pos_o[POS_OUT_W-1:0];
      out_data.cell_data       <= (op_q == OP_READ) ? rdata : 16'h0000;
      out_data.scrolled        <= scr_next;
    end
  end

  assign stat.op          = op_q;
  assign stat.scroll_need = scroll_need;
  assign stat.copy_last   = (ptr == COPY_LAST);
  assign stat.cell_last   = (ptr == CELL_LAST);
  assign stat.out_free    = !out_valid || out_ready;

`ifndef SYNTHESIS
  // one write source per cycle on the single write port
  a_one_writer: assert property (@(posedge clk) disable iff (rst)
    $onehot0({pend, cmd.blank_wr, exec_wr}))
    else $error("screen store write sources collide");

  a_cursor_range: assert property (@(posedge clk) disable iff (rst)
    (cur_col <= LAST_COL) && (cur_row <= LAST_ROW))
    else $error("cursor outside screen");

  a_load_free: assert property (@(posedge clk) disable iff (rst)
    cmd.out_load |-> stat.out_free)
    else $error("result register overwritten");

  a_scroll_row: assert property (@(posedge clk) disable iff (rst)
    (cmd.exec && (op_q == OP_PUT) && scroll_need) |=> (cur_row == LAST_ROW) && scr)
    else $error("scroll left cursor off last row");
`endif

endmodule

`default_nettype wire

>>> sv/text_console_character_engine.sv
// text_console_character_engine: top level of the text console character engine
// joins the controller tcce_ctrl and the datapath tcce_datapath; uses tcce_pkg
//
// usage
// - input channel in_valid/in_ready/in_data carries one operation per transaction:
//   put character, clear screen, set cursor or read cell
// - output channel out_valid/out_ready/out_data returns exactly one result per
//   input transaction, in order: cursor, linear position, read data, scroll flag
// - cfg_we/cfg_wdata write the text color attribute, no wait;
//   write it only while no transaction is in flight
// - put (no scroll) and set cursor: result loaded in the execute state if free
// - read cell: adds a read state for the registered read port of the store
// - clear: the whole store is blanked, one cell blanked per cycle
// - put that scrolls: the store is copied one cell per cycle through its
//   single read and single write port, then the bottom row is blanked
// - after reset the store is filled with blank cells (attribute 0x07), one
//   cell per cycle over all COLUMNS*ROWS cells; in_ready stays low until
//   that pass ends, configuration writes are taken throughout
// - a stalled receiver holds the result in the output register; the next
//   transaction is still accepted and runs up to its result, then waits
`default_nettype none

module text_console_character_engine import tcce_pkg::*; #(
  parameter int COLUMNS = COLUMNS_DEF,
  parameter int ROWS    = ROWS_DEF
) (
  input  logic       clk,
  input  logic       rst,
  // input transactions
  input  logic       in_valid,
  output logic       in_ready,
  input  in_t        in_data,
  // result transactions
  output logic       out_valid,
  input  logic       out_ready,
  output out_t       out_data,
  // text color register
  input  logic       cfg_we,
  input  logic [7:0] cfg_wdata
);

  cmd_t  cmd;
  stat_t stat;

  // sequencing: init pass, accept, execute, sweeps, result hand-off
  tcce_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  // cursor, screen store and result register
  tcce_datapath #(
    .COLUMNS (COLUMNS),
    .ROWS    (ROWS)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .in_data   (in_data),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .cmd       (cmd),
    .stat      (stat),
    .out_ready (out_ready),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

endmodule

`default_nettype wire

>>> sim/text_console_character_engine_tb.sv
// text_console_character_engine_tb: self-checking bench for the text console engine
// drives put, clear, set cursor and read cell transactions and checks every report
// against an in-bench model of the screen; depends on tcce_pkg and the engine rtl
`timescale 1ns / 1ps

module text_console_character_engine_tb import tcce_pkg::*; ();

  // screen geometry, same as the engine defaults
  localparam int SCREEN_COLS  = COLUMNS_DEF;
  localparam int SCREEN_ROWS  = ROWS_DEF;
  localparam int SCREEN_CELLS = SCREEN_COLS * SCREEN_ROWS;

  // random part: phases of items with a color write in between
  localparam int RANDOM_PHASES = 5;
  localparam int PHASE_ITEMS   = 105;

  // a scroll or clear walks the whole store; with the receiver hold and the longest
  // sender gap that sets the worst case, and this limit is many times it
  localparam int STALL_LIMIT = 20000;
  localparam int LONG_HOLD   = 400;
  localparam int HOLD_AFTER  = 100;
  localparam int MAX_REPORTS = 10;

  logic       clk;
  logic       rst;
  logic       in_valid;
  logic       in_ready;
  in_t        in_data;
  logic       out_valid;
  logic       out_ready;
  out_t       out_data;
  logic       cfg_we;
  logic [7:0] cfg_wdata;

  text_console_character_engine #(
    .COLUMNS(SCREEN_COLS),
    .ROWS   (SCREEN_ROWS)
  ) dut (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // screen model: its own copy of the store, cursor and text color
  // ---------------------------------------------------------------------------
  logic [15:0] screen_model [0:SCREEN_CELLS-1];
  int unsigned model_col;
  int unsigned model_row;
  logic [7:0]  model_color;

  // transactions waiting to be offered, and reports still owed by the engine
  in_t  queued_ops[$];
  out_t predicted_reports[$];

  int unsigned ops_queued;
  int unsigned ops_accepted;
  int unsigned reports_seen;
  int unsigned fail_count;

  // idle modes, switched per phase so some stretches run without gaps
  bit tx_idle_on;
  bit rx_idle_on;

  // shift every row up one line and blank the bottom row in the current color
  function automatic void scroll_screen();
    for (int i = 0; i < SCREEN_CELLS - SCREEN_COLS; i++)
      screen_model[i] = screen_model[i + SCREEN_COLS];
    for (int i = SCREEN_CELLS - SCREEN_COLS; i < SCREEN_CELLS; i++)
      screen_model[i] = {model_color, BLANK_CHAR};
  endfunction

  // put one character code, returns 1 when the screen scrolled
  function automatic bit put_glyph(logic [7:0] code);
    case (code)
      CH_LF: begin
        model_col = 0;
        model_row++;
      end
      CH_CR: model_col = 0;
      CH_TAB: begin
        // next tab stop, wrapping to the next line at the right edge
        model_col = (model_col + TAB_STEP) & ~(TAB_STEP - 1);
        if (model_col >= SCREEN_COLS) begin
          model_col = 0;
          model_row++;
        end
      end
      CH_BS: begin
        // backspace stops at the left edge, else blanks the cell it steps onto
        if (model_col > 0) begin
          model_col--;
          screen_model[model_row * SCREEN_COLS + model_col] = {model_color, BLANK_CHAR};
        end
      end
      default: begin
        screen_model[model_row * SCREEN_COLS + model_col] = {model_color, code};
        model_col++;
        if (model_col >= SCREEN_COLS) begin
          model_col = 0;
          model_row++;
        end
      end
    endcase
    if (model_row >= SCREEN_ROWS) begin
      scroll_screen();
      model_row = SCREEN_ROWS - 1;
      return 1'b1;
    end
    return 1'b0;
  endfunction

  // apply one operation to the model and build the report it should produce
  function automatic out_t apply_console_op(in_t op_item);
    out_t        report;
    int unsigned col_c;
    int unsigned row_c;
    int unsigned lin_pos;
    report = '0;
    // coordinates past the screen clamp to the last column and row
    col_c = (op_item.col_in > SCREEN_COLS - 1) ? SCREEN_COLS - 1 : op_item.col_in;
    row_c = (op_item.row_in > SCREEN_ROWS - 1) ? SCREEN_ROWS - 1 : op_item.row_in;
    case (op_item.operation)
      OP_PUT: report.scrolled = put_glyph(op_item.char_code);
      OP_CLEAR: begin
        for (int i = 0; i < SCREEN_CELLS; i++)
          screen_model[i] = {model_color, BLANK_CHAR};
        model_col = 0;
        model_row = 0;
      end
      OP_SET: begin
        model_col = col_c;
        model_row = row_c;
      end
      OP_READ: report.cell_data = screen_model[row_c * SCREEN_COLS + col_c];
    endcase
    lin_pos = model_row * SCREEN_COLS + model_col;
    report.cursor_col      = model_col[COL_OUT_W-1:0];
    report.cursor_row      = model_row[ROW_OUT_W-1:0];
    report.cursor_position = lin_pos[POS_OUT_W-1:0];
    return report;
  endfunction

  // idle gap: mostly none or short, now and then a long one
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 15);
    return $urandom_range(30, 120);
  endfunction

  function automatic in_t make_op(logic [1:0] op, logic [7:0] code, logic [7:0] col,
                                  logic [7:0] row);
    in_t op_item;
    op_item.operation = op;
    op_item.char_code = code;
    op_item.col_in    = col;
    op_item.row_in    = row;
    return op_item;
  endfunction

  // random operation, weighted toward puts and toward the right and bottom
  // edges so wraps and scrolls happen often
  function automatic in_t random_op();
    in_t         op_item;
    int unsigned r;
    op_item.char_code = 8'($urandom_range(0, 255));
    op_item.col_in    = 8'($urandom_range(0, 255));
    op_item.row_in    = 8'($urandom_range(0, 255));
    r = $urandom_range(0, 99);
    if (r < 2) begin
      op_item.operation = OP_CLEAR;
    end else if (r < 14) begin
      op_item.operation = OP_SET;
      r = $urandom_range(0, 99);
      if (r < 40) op_item.col_in = 8'($urandom_range(SCREEN_COLS - 8, SCREEN_COLS - 1));
      else if (r >= 60) op_item.col_in = 8'($urandom_range(0, SCREEN_COLS - 1));
      r = $urandom_range(0, 99);
      if (r < 40) op_item.row_in = 8'($urandom_range(SCREEN_ROWS - 3, SCREEN_ROWS - 1));
      else if (r >= 55) op_item.row_in = 8'($urandom_range(0, SCREEN_ROWS - 1));
    end else if (r < 28) begin
      op_item.operation = OP_READ;
      if ($urandom_range(0, 99) < 80) begin
        op_item.col_in = 8'($urandom_range(0, SCREEN_COLS - 1));
        op_item.row_in = 8'($urandom_range(0, SCREEN_ROWS - 1));
      end
    end else begin
      op_item.operation = OP_PUT;
      r = $urandom_range(0, 99);
      if (r < 10) op_item.char_code = CH_LF;
      else if (r < 15) op_item.char_code = CH_CR;
      else if (r < 23) op_item.char_code = CH_TAB;
      else if (r < 33) op_item.char_code = CH_BS;
    end
    return op_item;
  endfunction

  task automatic queue_op(in_t op_item);
    queued_ops.push_back(op_item);
    ops_queued++;
  endtask

  // sender pause: every queued transaction accepted and every report back
  task automatic wait_drained();
    while (!(ops_accepted == ops_queued && predicted_reports.size() == 0))
      @(posedge clk);
  endtask

  // color write while the engine is idle
  task automatic write_color(logic [7:0] color);
    repeat (4) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= color;
    @(posedge clk);
    cfg_we    <= 1'b0;
  endtask

  // ---------------------------------------------------------------------------
  // driver: offers queued transactions, predicts each one as it is accepted
  // ---------------------------------------------------------------------------
  int unsigned tx_gap;

  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
      tx_gap = 0;
    end else begin
      // the model follows the color register at the same edge as the engine
      if (cfg_we)
        model_color = cfg_wdata;
      if (in_valid && in_ready) begin
        predicted_reports.push_back(apply_console_op(in_data));
        ops_accepted++;
      end
      // the slot is free when nothing is offered or the offer was just taken
      if (!in_valid || in_ready) begin
        if (tx_gap > 0) begin
          tx_gap--;
          in_valid <= 1'b0;
        end else if (queued_ops.size() > 0) begin
          in_data  <= queued_ops.pop_front();
          in_valid <= 1'b1;
          tx_gap = tx_idle_on ? pick_gap() : 0;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // monitor and receiver: checks each report, drives out_ready with random
  // stalls and one long hold-off so the engine fills up and stalls its input
  // ---------------------------------------------------------------------------
  int unsigned rx_gap;
  int unsigned hold_cycles;
  bit          long_hold_done;

  always @(posedge clk) begin
    out_t want;
    if (rst) begin
      out_ready <= 1'b0;
      rx_gap      = 0;
      hold_cycles = 0;
    end else begin
      if (out_valid && out_ready) begin
        reports_seen++;
        if (predicted_reports.size() == 0) begin
          fail_count++;
          if (fail_count <= MAX_REPORTS)
            $display("unexpected report: col %0d row %0d pos %0d cell %h scrolled %0b",
                     out_data.cursor_col, out_data.cursor_row, out_data.cursor_position,
                     out_data.cell_data, out_data.scrolled);
        end else begin
          want = predicted_reports.pop_front();
          if (out_data.cursor_col !== want.cursor_col ||
              out_data.cursor_row !== want.cursor_row ||
              out_data.cursor_position !== want.cursor_position ||
              out_data.cell_data !== want.cell_data ||
              out_data.scrolled !== want.scrolled) begin
            fail_count++;
            if (fail_count <= MAX_REPORTS) begin
              $display("report %0d expected col %0d row %0d pos %0d cell %h scrolled %0b",
                       reports_seen, want.cursor_col, want.cursor_row,
                       want.cursor_position, want.cell_data, want.scrolled);
              $display("report %0d got      col %0d row %0d pos %0d cell %h scrolled %0b",
                       reports_seen, out_data.cursor_col, out_data.cursor_row,
                       out_data.cursor_position, out_data.cell_data, out_data.scrolled);
            end
          end
        end
        if (rx_idle_on)
          rx_gap = pick_gap();
      end
      // one long hold-off early in the random part, within its first phase
      if (!long_hold_done && reports_seen >= HOLD_AFTER) begin
        long_hold_done = 1'b1;
        hold_cycles    = LONG_HOLD;
      end
      if (hold_cycles > 0) begin
        hold_cycles--;
        out_ready <= 1'b0;
      end else if (rx_gap > 0) begin
        rx_gap--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // watchdog: too long without any transaction on either channel
  // ---------------------------------------------------------------------------
  initial begin
    int unsigned quiet;
    quiet = 0;
    forever begin
      @(posedge clk);
      if ((in_valid && in_ready) || (out_valid && out_ready))
        quiet = 0;
      else
        quiet++;
      if (quiet >= STALL_LIMIT)
        break;
    end
    $display("timeout: no transaction for %0d cycles", STALL_LIMIT);
    $display("status: fail");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // main sequence
  // ---------------------------------------------------------------------------
  initial begin
    logic [7:0] color;
    rst       = 1'b1;
    in_valid  = 1'b0;
    in_data   = '0;
    out_ready = 1'b0;
    cfg_we    = 1'b0;
    cfg_wdata = '0;
    tx_idle_on = 1'b1;
    rx_idle_on = 1'b1;
    ops_queued   = 0;
    ops_accepted = 0;
    reports_seen = 0;
    fail_count   = 0;
    long_hold_done = 1'b0;

    // reset state of the model: blank screen in the reset attribute, cursor home
    model_color = RESET_ATTR;
    model_col   = 0;
    model_row   = 0;
    for (int i = 0; i < SCREEN_CELLS; i++)
      screen_model[i] = {RESET_ATTR, BLANK_CHAR};

    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // directed part, reset color; the engine clears its store first and holds
    // in_ready low meanwhile, the offers simply wait
    queue_op(make_op(OP_READ,  8'h00,  8'd0,   8'd0));    // reset content
    queue_op(make_op(OP_PUT,   8'h41,  8'd0,   8'd0));
    queue_op(make_op(OP_PUT,   8'h00,  8'd0,   8'd0));    // lowest code
    queue_op(make_op(OP_PUT,   8'hFF,  8'd0,   8'd0));    // highest code
    queue_op(make_op(OP_PUT,   CH_BS,  8'd0,   8'd0));    // backspace blanks
    queue_op(make_op(OP_READ,  8'h00,  8'd2,   8'd0));
    queue_op(make_op(OP_PUT,   CH_CR,  8'd0,   8'd0));
    queue_op(make_op(OP_PUT,   CH_BS,  8'd0,   8'd0));    // backspace at left edge
    queue_op(make_op(OP_PUT,   CH_TAB, 8'd0,   8'd0));
    queue_op(make_op(OP_PUT,   CH_LF,  8'd0,   8'd0));
    queue_op(make_op(OP_SET,   8'h00,  8'hFF,  8'hFF));   // clamped to bottom right
    queue_op(make_op(OP_PUT,   8'h5A,  8'd0,   8'd0));    // wrap past last cell scrolls
    queue_op(make_op(OP_READ,  8'h00,  8'hFF,  8'hFF));
    queue_op(make_op(OP_READ,  8'h00,  8'd79,  8'd23));
    queue_op(make_op(OP_SET,   8'h00,  8'd75,  8'd24));
    queue_op(make_op(OP_PUT,   CH_TAB, 8'd0,   8'd0));    // tab wraps on last row
    queue_op(make_op(OP_SET,   8'h00,  8'd3,   8'd24));
    queue_op(make_op(OP_PUT,   CH_LF,  8'd0,   8'd0));    // newline on last row
    queue_op(make_op(OP_SET,   8'h00,  8'd72,  8'd10));
    queue_op(make_op(OP_PUT,   CH_TAB, 8'd0,   8'd0));    // tab wraps mid screen
    queue_op(make_op(OP_SET,   8'h00,  8'd0,   8'd0));
    queue_op(make_op(OP_PUT,   8'h7F,  8'd0,   8'd0));
    queue_op(make_op(OP_READ,  8'h00,  8'd0,   8'd0));
    queue_op(make_op(OP_CLEAR, 8'h00,  8'd0,   8'd0));
    queue_op(make_op(OP_READ,  8'h00,  8'hFF,  8'd0));
    wait_drained();

    // random part: each phase runs with its own color, extremes first
    for (int p = 0; p < RANDOM_PHASES; p++) begin
      case (p)
        0:       color = 8'h00;
        1:       color = 8'hFF;
        2:       color = 8'h4F;
        default: color = 8'($urandom_range(0, 255));
      endcase
      write_color(color);
      tx_idle_on = (p != 2);
      rx_idle_on = (p != 3);
      for (int k = 0; k < PHASE_ITEMS; k++)
        queue_op(random_op());
      wait_drained();
    end

    // tail: give a stray extra report time to show up
    repeat (50) @(posedge clk);
    if (predicted_reports.size() != 0) begin
      fail_count++;
      $display("%0d reports never arrived", predicted_reports.size());
    end
    if (fail_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
